// File: hw/rtl/edf_pkg.sv
// Shared types and constants for the EDF task scheduler.
package edf_pkg;
   localparam int TASKS = 8;
   localparam int IDX_W = $clog2(TASKS);

   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_LOAD    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic [1:0] CSR_NUM_PERIODIC  = 2'd0;
   localparam logic [1:0] CSR_NUM_APERIODIC = 2'd1;
   localparam logic [1:0] CSR_APER_WINDOW   = 2'd2;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 144;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // write table slot from request
      logic restart;   // init per-slot state for slot at index
      logic rel;       // aperiodic release step for slot at index
      logic per;       // periodic re-release step for slot at index
      logic pick;      // earliest-deadline compare for slot at index
      logic decide;    // preempt/dispatch/charge
      logic clear;     // clear tick-scoped scratch
   } edf_cmd_type;
endpackage

// File: hw/rtl/edf_ctrl.sv
// Controller state machine: walks slots for restart, release and selection phases.
module edf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_mode,
   input  logic                        rsp_busy,
   output logic                        rsp_load,
   output edf_pkg::edf_cmd_type        cmd,
   output logic [edf_pkg::IDX_W-1:0]   idx
);
   typedef enum logic [2:0] {S_IDLE, S_RST, S_REL, S_PER, S_PICK, S_DEC, S_OUT} state_type;
   state_type state_ff, state_in;
   logic [edf_pkg::IDX_W-1:0] idx_ff, idx_in;
   localparam logic [edf_pkg::IDX_W-1:0] LAST = edf_pkg::IDX_W'(edf_pkg::TASKS - 1);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      req_tready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               idx_in = '0;
               cmd.clear = 1'b1;
               if (req_mode == edf_pkg::MODE_RESTART) state_in = S_RST;
               else if (req_mode == edf_pkg::MODE_TICK) state_in = S_REL;
               else begin
                  cmd.load = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_RST: begin
            cmd.restart = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST) state_in = S_OUT;
         end
         S_REL: begin
            cmd.rel = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST) state_in = S_PER;
         end
         S_PER: begin
            cmd.per = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST) state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST) state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_busy) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign idx = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end
endmodule

// File: hw/rtl/edf_dpath.sv
// Datapath: task table, per-slot run state, selection and counters.
module edf_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  edf_pkg::edf_cmd_type      cmd,
   input  logic [edf_pkg::IDX_W-1:0] idx,
   input  logic [1:0]                in_mode,
   input  logic [2:0]                in_slot,
   input  logic [7:0]                in_task_id,
   input  logic [15:0]               in_period,
   input  logic [15:0]               in_exec_budget,
   input  logic [15:0]               in_release_at,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output logic [edf_pkg::RSP_DATA_W-1:0] rsp_word
);
   localparam int TASKS = edf_pkg::TASKS;
   localparam int IW = edf_pkg::IDX_W;
   localparam int CW = $clog2(TASKS + 1);

   logic [3:0]  np_cfg_ff, na_cfg_ff;
   logic [15:0] window_ff;

   logic [15:0] tbl_period_ff [TASKS];
   logic [15:0] tbl_budget_ff [TASKS];
   logic [15:0] tbl_release_ff [TASKS];
   logic [7:0]  tbl_ident_ff [TASKS];

   logic [15:0] left_ff [TASKS];
   logic [31:0] dl_ff [TASKS];
   logic [15:0] cd_ff [TASKS];
   logic [31:0] qo_ff [TASKS];
   logic [TASKS-1:0] ready_ff, pending_ff;
   logic [31:0] order_ff, tick_ff, pre_tot_ff, miss_tot_ff;
   logic        cur_valid_ff, started_ff;
   logic [IW-1:0] cur_ff;
   logic [7:0]  missed_ff;
   logic        next_valid_ff;
   logic [IW-1:0] next_ff;
   logic [31:0] next_dl_ff, next_age_ff;
   logic        mode_tick_ff;

   // clamped slot counts
   logic [CW-1:0] np_c, end_c;
   logic [4:0] end_raw;
   always_comb begin
      np_c = (np_cfg_ff > 4'(TASKS)) ? CW'(TASKS) : CW'(np_cfg_ff);
      end_raw = 5'(np_c) + 5'(na_cfg_ff);
      end_c = (end_raw > 5'(TASKS)) ? CW'(TASKS) : CW'(end_raw);
   end

   // per-index scratch
   logic        is_per, is_aper;
   logic [15:0] cd_dec;
   logic [31:0] age_i;
   logic        better;
   always_comb begin
      is_per  = CW'(idx) < np_c;
      is_aper = !is_per && (CW'(idx) < end_c);
      cd_dec  = (cd_ff[idx] != 16'd0) ? cd_ff[idx] - 16'd1 : 16'd0;
      age_i   = order_ff - qo_ff[idx];
      better  = !next_valid_ff || (dl_ff[idx] < next_dl_ff) ||
                (dl_ff[idx] == next_dl_ff && age_i > next_age_ff);
   end

   logic do_pre, do_run;
   logic [IW-1:0] run_slot;
   always_comb begin
      do_pre = cur_valid_ff && next_valid_ff && (next_dl_ff < dl_ff[cur_ff]);
      do_run = (cur_valid_ff && !do_pre) || next_valid_ff;
      run_slot = (cur_valid_ff && !do_pre) ? cur_ff : next_ff;
   end

   logic [15:0] left_after;
   assign left_after = (left_ff[run_slot] != 16'd0) ? left_ff[run_slot] - 16'd1 : 16'd0;

   logic        o_idle, o_pre;
   logic [2:0]  o_rs, o_pfrom, o_pto;
   logic [7:0]  o_id;
   logic [15:0] o_rem;
   logic [31:0] o_tick;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load && in_mode == edf_pkg::MODE_LOAD && 32'(in_slot) < TASKS) begin
         tbl_ident_ff[IW'(in_slot)]   <= in_task_id;
         tbl_period_ff[IW'(in_slot)]  <= in_period;
         tbl_budget_ff[IW'(in_slot)]  <= in_exec_budget;
         tbl_release_ff[IW'(in_slot)] <= in_release_at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         np_cfg_ff <= '0; na_cfg_ff <= '0; window_ff <= 16'd500;
         for (int i = 0; i < TASKS; i++) begin
            left_ff[i] <= '0; dl_ff[i] <= '0; cd_ff[i] <= '0; qo_ff[i] <= '0;
         end
         ready_ff <= '0; pending_ff <= '0; order_ff <= '0; tick_ff <= '0;
         pre_tot_ff <= '0; miss_tot_ff <= '0; cur_valid_ff <= 1'b0; cur_ff <= '0;
         started_ff <= 1'b0; missed_ff <= '0; next_valid_ff <= 1'b0; next_ff <= '0;
         next_dl_ff <= '0; next_age_ff <= '0; mode_tick_ff <= 1'b0;
         o_idle <= 1'b0; o_pre <= 1'b0; o_rs <= '0; o_pfrom <= '0; o_pto <= '0;
         o_id <= '0; o_rem <= '0; o_tick <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               edf_pkg::CSR_NUM_PERIODIC:  np_cfg_ff <= csr_wdata[3:0];
               edf_pkg::CSR_NUM_APERIODIC: na_cfg_ff <= csr_wdata[3:0];
               edf_pkg::CSR_APER_WINDOW:   window_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            missed_ff <= '0; next_valid_ff <= 1'b0;
            mode_tick_ff <= (in_mode == edf_pkg::MODE_TICK) && started_ff;
            o_idle <= (in_mode == edf_pkg::MODE_TICK); o_pre <= 1'b0;
            o_rs <= '0; o_pfrom <= '0; o_pto <= '0; o_id <= '0; o_rem <= '0; o_tick <= '0;
            if (in_mode == edf_pkg::MODE_RESTART) begin
               ready_ff <= '0; pending_ff <= '0; order_ff <= '0;
               o_idle <= 1'b0;
            end
         end
         if (cmd.restart) begin
            // one slot per cycle; enqueue order follows slot order
            left_ff[idx] <= '0; dl_ff[idx] <= '0; cd_ff[idx] <= '0; qo_ff[idx] <= '0;
            if (is_per) begin
               left_ff[idx] <= tbl_budget_ff[idx];
               dl_ff[idx]   <= 32'(tbl_period_ff[idx]);
               cd_ff[idx]   <= tbl_period_ff[idx];
               qo_ff[idx]   <= order_ff;
               ready_ff[idx] <= 1'b1;
               order_ff <= order_ff + 32'd1;
            end else if (is_aper) begin
               left_ff[idx] <= tbl_budget_ff[idx];
               dl_ff[idx]   <= 32'(tbl_release_ff[idx]) + 32'(window_ff);
               pending_ff[idx] <= 1'b1;
            end
            if (idx == IW'(TASKS - 1)) begin
               cur_valid_ff <= 1'b0; tick_ff <= '0; pre_tot_ff <= '0;
               miss_tot_ff <= '0; started_ff <= 1'b1;
            end
         end
         // aperiodic releases get their queue order ahead of periodic re-releases
         if (cmd.rel && mode_tick_ff) begin
            if (pending_ff[idx] && 32'(tbl_release_ff[idx]) == tick_ff) begin
               pending_ff[idx] <= 1'b0;
               left_ff[idx] <= tbl_budget_ff[idx];
               dl_ff[idx] <= tick_ff + 32'(window_ff);
               ready_ff[idx] <= 1'b1;
               qo_ff[idx] <= order_ff;
               order_ff <= order_ff + 32'd1;
            end
         end
         if (cmd.per && mode_tick_ff && tick_ff != 32'd0 && is_per) begin
            cd_ff[idx] <= cd_dec;
            if (cd_dec == 16'd0 && tbl_period_ff[idx] != 16'd0) begin
               cd_ff[idx] <= tbl_period_ff[idx];
               if (left_ff[idx] != 16'd0) begin
                  missed_ff[idx] <= 1'b1;
                  miss_tot_ff <= sat_inc(miss_tot_ff);
               end
               left_ff[idx] <= tbl_budget_ff[idx];
               dl_ff[idx] <= tick_ff + 32'(tbl_period_ff[idx]);
               if (!ready_ff[idx] && !(cur_valid_ff && cur_ff == idx)) begin
                  ready_ff[idx] <= 1'b1;
                  qo_ff[idx] <= order_ff;
                  order_ff <= order_ff + 32'd1;
               end
            end
         end
         if (cmd.pick && mode_tick_ff && ready_ff[idx] && better) begin
            next_valid_ff <= 1'b1; next_ff <= idx;
            next_dl_ff <= dl_ff[idx]; next_age_ff <= age_i;
         end
         if (cmd.decide && mode_tick_ff) begin
            o_tick <= tick_ff;
            tick_ff <= tick_ff + 32'd1;
            if (do_pre) begin
               o_pre <= 1'b1;
               o_pfrom <= 3'(cur_ff); o_pto <= 3'(next_ff);
               pre_tot_ff <= sat_inc(pre_tot_ff);
               ready_ff[cur_ff] <= 1'b1;
               qo_ff[cur_ff] <= order_ff;
               order_ff <= order_ff + 32'd1;
            end
            if (do_run) begin
               if (!(cur_valid_ff && !do_pre)) ready_ff[next_ff] <= 1'b0;
               left_ff[run_slot] <= left_after;
               o_idle <= 1'b0;
               o_rs <= 3'(run_slot);
               o_id <= tbl_ident_ff[run_slot];
               o_rem <= left_after;
               cur_valid_ff <= (left_after != 16'd0);
               cur_ff <= run_slot;
            end else begin
               o_idle <= 1'b1;
               cur_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_word = {5'd0, miss_tot_ff, pre_tot_ff, o_pto, o_pfrom, o_pre,
                      missed_ff & {8{mode_tick_ff}}, o_rem, o_id, o_rs, o_idle, o_tick};
endmodule

// File: hw/rtl/edf_task_scheduler_core.sv
// Top level of the EDF task scheduler: controller, datapath and response register.
// Requests are handled one at a time: a tick walks the aperiodic release,
// periodic re-release and earliest-deadline passes, one slot per cycle, then a decide step;
// restart walks every slot once and load writes one table slot. The response register
// lets the next request enter while a response waits.
// Synchronous active-high reset clears control, counters and run state; table stays undefined.
module edf_task_scheduler_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], slot[4:2], task_id[12:5], period[28:13], exec_budget[44:29], release_at[60:45]
   input  logic [edf_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tick_number[31:0], idle[32], running_slot[35:33], running_id[43:36],
   // remaining_time[59:44], missed_mask[67:60], preempted[68], preempted_slot[71:69],
   // preempting_slot[74:72], preempt_sum[106:75], miss_sum[138:107]
   output logic [143:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   edf_pkg::edf_cmd_type cmd;
   logic [edf_pkg::IDX_W-1:0] idx;
   logic rsp_load;
   logic [edf_pkg::RSP_DATA_W-1:0] word;
   logic rsp_valid_ff;
   logic [143:0] rsp_data_ff;

   edf_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_mode(req_tdata[1:0]),
      .rsp_busy(rsp_valid_ff && !rsp_tready), .rsp_load, .cmd, .idx
   );

   edf_dpath u_dpath (
      .clock, .reset, .cmd, .idx,
      .in_mode(req_tdata[1:0]), .in_slot(req_tdata[4:2]), .in_task_id(req_tdata[12:5]),
      .in_period(req_tdata[28:13]), .in_exec_budget(req_tdata[44:29]),
      .in_release_at(req_tdata[60:45]),
      .csr_we, .csr_index, .csr_wdata, .rsp_word(word)
   );

   // datapath reads the request only during the accept cycle, where load/clear use it; the
   // sender must hold it stable until then, and the block itself does not enforce that.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (rsp_load) rsp_data_ff <= word;
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// File: hw/rtl/edf_task_scheduler_core_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module edf_task_scheduler_core_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp dropped");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[59:33] == 27'd0) else $error("idle with task");
   a_pre_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[68] |-> rsp_tdata[74:69] == 6'd0) else $error("stray preempt");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accepted twice");
endmodule

bind edf_task_scheduler_core edf_task_scheduler_core_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// File: tb/edf_task_scheduler_checker.sv
// Checker for the EDF scheduler: tracks requests, predicts responses, compares them.
`timescale 1ns / 1ps
module edf_task_scheduler_checker #(
   parameter int TASKS = edf_pkg::TASKS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count
);
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] release_at;
      logic [15:0] exec_budget;
      logic [15:0] period;
      logic [7:0]  task_id;
      logic [2:0]  slot;
      logic [1:0]  mode;
   } sched_req_type;

   typedef struct packed {
      logic [31:0] miss_sum;
      logic [31:0] preempt_sum;
      logic [2:0]  preempting_slot;
      logic [2:0]  preempted_slot;
      logic        preempted;
      logic [7:0]  missed_mask;
      logic [15:0] remaining_time;
      logic [7:0]  running_id;
      logic [2:0]  running_slot;
      logic        idle;
      logic [31:0] tick_number;
   } sched_rsp_type;

   // configuration copy
   logic [3:0]  cfg_periodic, cfg_aperiodic;
   logic [15:0] cfg_window;

   // task table and run state
   logic [15:0] tbl_period [TASKS];
   logic [15:0] tbl_budget [TASKS];
   logic [15:0] tbl_release[TASKS];
   logic [7:0]  tbl_ident  [TASKS];
   logic [15:0] budget     [TASKS];
   logic [31:0] deadline   [TASKS];
   logic [15:0] countdown  [TASKS];
   logic [31:0] age_stamp  [TASKS];
   logic [TASKS-1:0] ready_set, waiting_set;
   logic [31:0] age_next, tick_now, preempt_cnt, miss_cnt;
   int          running;
   logic        run_active;

   sched_rsp_type rsp_expected[$];

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic void put_ready(int i);
      ready_set[i] = 1'b1;
      age_stamp[i] = age_next;
      age_next = age_next + 32'd1;
   endfunction

   function automatic void clear_run();
      for (int i = 0; i < TASKS; i++) begin
         budget[i] = '0; deadline[i] = '0; countdown[i] = '0; age_stamp[i] = '0;
      end
      ready_set = '0; waiting_set = '0; age_next = '0;
      running = TASKS; tick_now = '0; preempt_cnt = '0; miss_cnt = '0;
   endfunction

   function automatic int periodic_slots();
      return (cfg_periodic > TASKS) ? TASKS : int'(cfg_periodic);
   endfunction

   function automatic void restart_run();
      int np, last;
      np = periodic_slots();
      last = np + int'(cfg_aperiodic);
      if (last > TASKS) last = TASKS;
      clear_run();
      for (int i = 0; i < np; i++) begin
         budget[i] = tbl_budget[i];
         deadline[i] = 32'(tbl_period[i]);
         countdown[i] = tbl_period[i];
         put_ready(i);
      end
      for (int i = np; i < last; i++) begin
         budget[i] = tbl_budget[i];
         deadline[i] = 32'(tbl_release[i]) + 32'(cfg_window);
         waiting_set[i] = 1'b1;
      end
      run_active = 1'b1;
   endfunction

   function automatic sched_rsp_type schedule_step(sched_req_type r);
      sched_rsp_type o;
      logic [TASKS-1:0] missed;
      int np, pick;
      o = '0;
      missed = '0;
      if (r.mode == edf_pkg::MODE_LOAD) begin
         tbl_ident[r.slot] = r.task_id;
         tbl_period[r.slot] = r.period;
         tbl_budget[r.slot] = r.exec_budget;
         tbl_release[r.slot] = r.release_at;
      end else if (r.mode == edf_pkg::MODE_RESTART) begin
         restart_run();
      end
      if (r.mode != edf_pkg::MODE_TICK || !run_active) begin
         o.idle = (r.mode == edf_pkg::MODE_TICK);
         o.preempt_sum = preempt_cnt;
         o.miss_sum = miss_cnt;
         return o;
      end

      // aperiodic releases
      for (int i = 0; i < TASKS; i++) begin
         if (waiting_set[i] && 32'(tbl_release[i]) == tick_now) begin
            waiting_set[i] = 1'b0;
            budget[i] = tbl_budget[i];
            deadline[i] = tick_now + 32'(cfg_window);
            put_ready(i);
         end
      end

      // periodic re-releases
      np = periodic_slots();
      if (tick_now != 0) begin
         for (int i = 0; i < np; i++) begin
            if (countdown[i] != 0) countdown[i] = countdown[i] - 16'd1;
            if (countdown[i] == 0 && tbl_period[i] != 0) begin
               countdown[i] = tbl_period[i];
               if (budget[i] != 0) begin
                  missed[i] = 1'b1;
                  miss_cnt = sat_inc(miss_cnt);
               end
               budget[i] = tbl_budget[i];
               deadline[i] = tick_now + 32'(tbl_period[i]);
               if (!ready_set[i] && running != i) put_ready(i);
            end
         end
      end

      // earliest deadline, oldest entry on ties
      pick = TASKS;
      for (int i = 0; i < TASKS; i++) begin
         if (!ready_set[i]) continue;
         if (pick == TASKS || deadline[i] < deadline[pick] ||
             (deadline[i] == deadline[pick] &&
              (age_next - age_stamp[i]) > (age_next - age_stamp[pick])))
            pick = i;
      end

      if (running < TASKS && pick < TASKS && deadline[pick] < deadline[running]) begin
         o.preempted = 1'b1;
         o.preempted_slot = 3'(running);
         o.preempting_slot = 3'(pick);
         preempt_cnt = sat_inc(preempt_cnt);
         put_ready(running);
         running = TASKS;
      end
      if (running >= TASKS && pick < TASKS) begin
         running = pick;
         ready_set[pick] = 1'b0;
      end

      o.tick_number = tick_now;
      if (running < TASKS) begin
         if (budget[running] != 0) budget[running] = budget[running] - 16'd1;
         o.running_slot = 3'(running);
         o.running_id = tbl_ident[running];
         o.remaining_time = budget[running];
         if (budget[running] == 0) running = TASKS;
      end else begin
         o.idle = 1'b1;
      end
      o.missed_mask = 8'(missed);
      o.preempt_sum = preempt_cnt;
      o.miss_sum = miss_cnt;
      tick_now = tick_now + 32'd1;
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s expected %0h got %0h", $realtime, name, exp_v, act_v);
      end
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      sched_rsp_type exp_r, act_r;
      if (reset) begin
         cfg_periodic <= 4'd0;
         cfg_aperiodic <= 4'd0;
         cfg_window <= 16'd500;
         clear_run();
         run_active = 1'b0;
         rsp_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act_r = sched_rsp_type'(rsp_tdata[138:0]);
            if (rsp_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%0t: response with none expected", $realtime);
            end else begin
               exp_r = rsp_expected.pop_front();
               check_field("tick_number", exp_r.tick_number, act_r.tick_number);
               check_field("idle", 32'(exp_r.idle), 32'(act_r.idle));
               check_field("running_slot", 32'(exp_r.running_slot), 32'(act_r.running_slot));
               check_field("running_id", 32'(exp_r.running_id), 32'(act_r.running_id));
               check_field("remaining_time", 32'(exp_r.remaining_time),
                           32'(act_r.remaining_time));
               check_field("missed_mask", 32'(exp_r.missed_mask), 32'(act_r.missed_mask));
               check_field("preempted", 32'(exp_r.preempted), 32'(act_r.preempted));
               check_field("preempted_slot", 32'(exp_r.preempted_slot),
                           32'(act_r.preempted_slot));
               check_field("preempting_slot", 32'(exp_r.preempting_slot),
                           32'(act_r.preempting_slot));
               check_field("preempt_sum", exp_r.preempt_sum, act_r.preempt_sum);
               check_field("miss_sum", exp_r.miss_sum, act_r.miss_sum);
            end
         end
         if (req_tvalid && req_tready)
            rsp_expected.insert(rsp_expected.size(),
                                schedule_step(sched_req_type'(req_tdata)));
         if (csr_we) begin
            case (csr_index)
               edf_pkg::CSR_NUM_PERIODIC:  cfg_periodic <= csr_wdata[3:0];
               edf_pkg::CSR_NUM_APERIODIC: cfg_aperiodic <= csr_wdata[3:0];
               edf_pkg::CSR_APER_WINDOW:   cfg_window <= csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = rsp_expected.size();
   end
endmodule

// File: tb/edf_task_scheduler_core_tb.sv
// Testbench top for the EDF scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module edf_task_scheduler_core_tb;
   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [63:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [143:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;
   int           fail_count, pending_count;
   int           sender_idle_pct, receiver_idle_pct;

   edf_task_scheduler_core dut (.*);

   edf_task_scheduler_checker u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);

   function automatic logic [63:0] pack_req(logic [1:0] mode, logic [2:0] slot,
                                            logic [7:0] id, logic [15:0] period,
                                            logic [15:0] exe, logic [15:0] rel);
      return {3'b000, rel, exe, period, id, slot, mode};
   endfunction

   // starts and ends at a falling edge; leaves tvalid high
   task automatic send_request(logic [63:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_slot(int s);
      logic [15:0] per, exe, rel;
      per = 16'($urandom_range(3, 40));
      exe = 16'($urandom_range(1, 8));
      rel = 16'($urandom_range(0, 80));
      case ($urandom_range(19))
         0: per = 16'd0;
         1: per = 16'($urandom);
         2: exe = 16'd0;
         3: exe = 16'($urandom_range(100, 65535));
         4: rel = 16'($urandom);
         default: ;
      endcase
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'(s), 8'($urandom), per, exe, rel));
   endtask

   task automatic random_request();
      int r;
      r = $urandom_range(99);
      if (r < 3) load_slot($urandom_range(7));
      else if (r < 4) send_request(pack_req(edf_pkg::MODE_RESTART, 3'($urandom),
                                            8'($urandom), 16'($urandom), 16'($urandom),
                                            16'($urandom)));
      else if (r < 5) send_request({$urandom, $urandom} | 64'd3);
      else send_request(pack_req(edf_pkg::MODE_TICK, 3'($urandom), 8'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   initial begin
      logic [15:0] window;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = edf_pkg::CSR_NUM_PERIODIC;
      csr_wdata = '0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tick before any restart, unused mode, extreme table entries
      write_csr(edf_pkg::CSR_NUM_PERIODIC, 16'd3);
      write_csr(edf_pkg::CSR_NUM_APERIODIC, 16'd2);
      send_request(pack_req(edf_pkg::MODE_TICK, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0));
      send_request(64'hFFFF_FFFF_FFFF_FFFF);
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'd0, 8'hFF, 16'd4, 16'd2, 16'hFFFF));
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'd1, 8'h00, 16'd6, 16'd0, 16'd0));
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'd2, 8'h5A, 16'd0, 16'd3, 16'd0));
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'd3, 8'hA5, 16'hFFFF, 16'd2, 16'd1));
      send_request(pack_req(edf_pkg::MODE_LOAD, 3'd4, 8'h11, 16'd1, 16'hFFFF, 16'd3));
      for (int s = 5; s < 8; s++) load_slot(s);
      send_request(pack_req(edf_pkg::MODE_RESTART, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0));
      repeat (12) send_request(pack_req(edf_pkg::MODE_TICK, 3'd7, 8'hFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 88 : 0;
         receiver_idle_pct = (phase < 2) ? 88 : (phase < 4) ? 12 : 0;
         case (phase)
            0: window = 16'd1;
            1: window = 16'hFFFF;
            default: window = 16'($urandom_range(5, 60));
         endcase
         write_csr(edf_pkg::CSR_NUM_PERIODIC, (phase == 2) ? 16'd15 : (phase == 3) ? 16'd0
                                              : 16'($urandom_range(1, 8)));
         write_csr(edf_pkg::CSR_NUM_APERIODIC, (phase == 3) ? 16'd15
                                               : 16'($urandom_range(0, 8)));
         write_csr(edf_pkg::CSR_APER_WINDOW, window);
         for (int s = 0; s < 8; s++) load_slot(s);
         send_request(pack_req(edf_pkg::MODE_RESTART, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0));
         for (int n = 0; n < 270; n++) begin
            random_request();
            // let the pipeline run dry once per phase
            if (n == 135) drain();
         end
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
